>>> src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned BITS_W     = 64;
  localparam int unsigned NBITS_W    = 6;
  localparam int unsigned FILL_W     = $clog2(BLK_WORDS);
  localparam int unsigned IDX_W      = $clog2(HASH_WORDS);
  localparam int unsigned RND_W      = $clog2(ROUNDS);
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // block buffer positions that steer the padding, and the last digest index and round
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLK_WORDS - 1);
  localparam logic [FILL_W-1:0] FILL_LEN  = FILL_W'(BLK_WORDS - 2);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HASH_WORDS - 1);
  localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(ROUNDS - 1);

  localparam logic [WORD_W-1:0]  PAD_MARK   = 32'h8000_0000;
  localparam logic [7:0]         PAD_BYTE   = 8'h80;
  localparam logic [NBITS_W-1:0] FULL_NBITS = NBITS_W'(WORD_W);

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_LAST_FULL,
    CMD_LAST_PART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [WORD_W-1:0]   word;
    logic [NBITS_W-1:0]  nbits;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } eng_ctl_t;

  function automatic logic [WORD_W-1:0] iv_word(input logic [IDX_W-1:0] i);
    logic [WORD_W-1:0] r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] i);
    logic [WORD_W-1:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> src/sha256_hash.sv
// SHA-256 over a word stream; words fill a 16-word block, one beat per cycle unless the back end stalls.
// The engine runs 64 rounds and a final add per block; the queue and buffer keep taking words
// meanwhile, but the word that completes the next block waits until the engine is idle.
// After the last word the back end pads, waits for a spilled length block or a block in flight,
// then shows the digest in 8 beats.
// Reset (rst_n low, synchronous) loads the initial hash and clears length, fill and queue.
module sha256_hash
  import sha_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // data_word [31:0], byte_count [34:32], zero fill [39:35]
  input  logic        in_tlast,    // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // digest_word [31:0]
  output logic [2:0]  out_tuser,   // word_index [2:0]
  output logic        out_tlast    // last_out
);

  // front end: register and classify each beat into a command
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;

  // queue to back end
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  sha_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // decouple: the front keeps taking beats while the engine grinds a block
  sha_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  // back end: fill the block, pad, compress, emit the digest and start afresh
  sha_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/sha_front.sv
module sha_front
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word [31:0], byte_count [34:32], zero fill
  input  logic        in_tlast,   // last_word
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [2:0] BC_NONE  = 3'd0;
  localparam logic [2:0] BC_ONE   = 3'd1;
  localparam logic [2:0] BC_TWO   = 3'd2;
  localparam logic [2:0] BC_THREE = 3'd3;

  logic              valid_r;
  cmd_t              cmd_r;
  cmd_t              cmd_nxt;
  logic [WORD_W-1:0] dw;
  logic [2:0]        bc;
  logic              take;

  assign dw   = in_tdata[31:0];
  assign bc   = in_tdata[34:32];
  assign in_tready = !valid_r || cmd_ready;
  assign take = in_tvalid && in_tready;

  // classify: a short last word carries its own pad marker
  always_comb begin
    cmd_nxt.word  = dw;
    cmd_nxt.nbits = FULL_NBITS;
    cmd_nxt.kind  = in_tlast ? CMD_LAST_FULL : CMD_DATA;
    if (in_tlast) begin
      case (bc)
        BC_NONE: begin
          cmd_nxt.kind  = CMD_LAST_PART;
          cmd_nxt.word  = PAD_MARK;
          cmd_nxt.nbits = NBITS_W'(0);
        end
        BC_ONE: begin
          cmd_nxt.kind  = CMD_LAST_PART;
          cmd_nxt.word  = {dw[31:24], PAD_BYTE, 16'h0000};
          cmd_nxt.nbits = NBITS_W'(8);
        end
        BC_TWO: begin
          cmd_nxt.kind  = CMD_LAST_PART;
          cmd_nxt.word  = {dw[31:16], PAD_BYTE, 8'h00};
          cmd_nxt.nbits = NBITS_W'(16);
        end
        BC_THREE: begin
          cmd_nxt.kind  = CMD_LAST_PART;
          cmd_nxt.word  = {dw[31:8], PAD_BYTE};
          cmd_nxt.nbits = NBITS_W'(24);
        end
        default: begin
          cmd_nxt.kind  = CMD_LAST_FULL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (cmd_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

>>> src/sha_queue.sv
module sha_queue
  import sha_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready = (cnt_r != CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

>>> src/sha_engine.sv
module sha_engine
  import sha_pkg::*;
(
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  eng_ctl_t                              ctl,
  input  logic [BLK_WORDS-1:0][WORD_W-1:0]      blk,
  output logic                                  busy,
  output logic [HASH_WORDS-1:0][WORD_W-1:0]     hash
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_ROUND,
    E_FINAL
  } eng_state_t;

  eng_state_t                           state_r;
  logic [RND_W-1:0]                     rnd_r;
  logic [HASH_WORDS-1:0][WORD_W-1:0]    hash_r;
  logic [HASH_WORDS-1:0][WORD_W-1:0]    v_r;
  logic [BLK_WORDS-1:0][WORD_W-1:0]     w_r;
  logic [HASH_WORDS-1:0][WORD_W-1:0]    v_nxt;
  logic [BLK_WORDS-1:0][WORD_W-1:0]     w_nxt;
  logic [WORD_W-1:0]                    t1;
  logic [WORD_W-1:0]                    t2;
  logic [WORD_W-1:0]                    ch;
  logic [WORD_W-1:0]                    maj;

  // one round: working words v_r[0..7] are a..h
  always_comb begin
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + big_sigma1(v_r[4]) + ch + round_k(rnd_r) + w_r[0];
    t2  = big_sigma0(v_r[0]) + maj;
    v_nxt[7] = v_r[6];
    v_nxt[6] = v_r[5];
    v_nxt[5] = v_r[4];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[3] = v_r[2];
    v_nxt[2] = v_r[1];
    v_nxt[1] = v_r[0];
    v_nxt[0] = t1 + t2;
    for (int i = 0; i < BLK_WORDS - 1; i++) begin
      w_nxt[i] = w_r[i + 1];
    end
    w_nxt[BLK_WORDS-1] = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      rnd_r   <= '0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_r[i] <= iv_word(IDX_W'(i));
      end
    end else begin
      case (state_r)
        E_IDLE: begin
          rnd_r <= '0;
          if (ctl.start) begin
            state_r <= E_ROUND;
          end else if (ctl.reinit) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
              hash_r[i] <= iv_word(IDX_W'(i));
            end
          end
        end
        E_ROUND: begin
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == RND_LAST) begin
            state_r <= E_FINAL;
          end
        end
        E_FINAL: begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            hash_r[i] <= hash_r[i] + v_r[i];
          end
          state_r <= E_IDLE;
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == E_IDLE && ctl.start) begin
      v_r <= hash_r;
      w_r <= blk;
    end else if (state_r == E_ROUND) begin
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  assign busy = (state_r != E_IDLE);
  assign hash = hash_r;

endmodule

>>> src/sha_back.sv
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // digest_word [31:0]
  output logic [2:0]  out_tuser,   // word_index [2:0]
  output logic        out_tlast    // last_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN_HI,
    S_LEN_LO,
    S_WAIT,
    S_OUT
  } back_state_t;

  back_state_t                         state_r, state_nxt;
  logic [FILL_W-1:0]                   fill_r;
  logic [BITS_W-1:0]                   bits_r, bits_nxt;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [WORD_W-1:0]                   block_r [BLK_WORDS-1];
  logic                                push_ok;
  logic                                push_en;
  logic [WORD_W-1:0]                   push_word;
  logic                                reinit;
  eng_ctl_t                            eng_ctl;
  logic                                eng_busy;
  logic [BLK_WORDS-1:0][WORD_W-1:0]    eng_blk;
  logic [HASH_WORDS-1:0][WORD_W-1:0]   eng_hash;

  // the word that completes a block needs the engine free
  assign push_ok = !(fill_r == FILL_LAST && eng_busy);

  always_comb begin
    state_nxt = state_r;
    bits_nxt  = bits_r;
    idx_nxt   = idx_r;
    push_en   = 1'b0;
    push_word = '0;
    cmd_ready = 1'b0;
    reinit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd_ready = push_ok;
        if (cmd_valid && push_ok) begin
          push_en   = 1'b1;
          push_word = cmd.word;
          bits_nxt  = bits_r + BITS_W'(cmd.nbits);
          case (cmd.kind)
            CMD_LAST_FULL: state_nxt = S_MARK;
            CMD_LAST_PART: state_nxt = S_ZERO;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_MARK: begin
        if (push_ok) begin
          push_en   = 1'b1;
          push_word = PAD_MARK;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill_r == FILL_LEN) begin
          state_nxt = S_LEN_HI;
        end else if (push_ok) begin
          push_en = 1'b1;
        end
      end
      S_LEN_HI: begin
        if (push_ok) begin
          push_en   = 1'b1;
          push_word = bits_r[BITS_W-1:WORD_W];
          state_nxt = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (push_ok) begin
          push_en   = 1'b1;
          push_word = bits_r[WORD_W-1:0];
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        idx_nxt = '0;
        if (!eng_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IDX_LAST) begin
            reinit    = 1'b1;
            bits_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bits_r  <= bits_nxt;
      idx_r   <= idx_nxt;
      if (push_en) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // the sixteenth word goes straight to the engine
  always_ff @(posedge clk) begin
    if (push_en && fill_r != FILL_LAST) begin
      block_r[fill_r] <= push_word;
    end
  end

  always_comb begin
    for (int i = 0; i < BLK_WORDS - 1; i++) begin
      eng_blk[i] = block_r[i];
    end
    eng_blk[BLK_WORDS-1] = push_word;
  end

  assign eng_ctl.start  = push_en && (fill_r == FILL_LAST);
  assign eng_ctl.reinit = reinit;

  sha_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (eng_ctl),
    .blk   (eng_blk),
    .busy  (eng_busy),
    .hash  (eng_hash)
  );

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = eng_hash[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == IDX_LAST);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eng_ctl.start |-> !eng_busy)
    else $error("block compression started while engine busy");

  a_out_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (!eng_busy && fill_r == '0))
    else $error("digest shown before final block settled");

  a_msg_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == S_IDLE && bits_r == '0))
    else $error("message state not cleared after last digest beat");

endmodule
